### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the seed resolver checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsr assertion failed");

`endif

### hw/rtl/tsr_pkg.sv
// ---------------------------------------------------------------------------
// tsr_pkg
// types and constants shared by the text seed resolver
// ---------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

    // result kinds
    localparam logic [1:0] KIND_NUMERIC = 2'd0;
    localparam logic [1:0] KIND_HASH    = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [31:0] HASH_MUL = 32'd31;
    localparam logic [67:0] RADIX    = 68'd10;

    localparam logic [63:0] INT64_MIN_MAG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT64_MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

    // one input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } char_item_t;

    // running parse state, also the snapshot handed to the formatter
    typedef struct packed {
        logic        started;
        logic [31:0] hash_run;
        logic [31:0] hash_last;
        logic [63:0] magnitude;
        logic        is_negative;
        logic        digits_seen;
        logic        numeric_ok;
        logic        overflowed;
        logic        pending_space;
    } acc_t;

    localparam acc_t ACC_RESET = '{
        started:       1'b0,
        hash_run:      32'd0,
        hash_last:     32'd0,
        magnitude:     64'd0,
        is_negative:   1'b0,
        digits_seen:   1'b0,
        numeric_ok:    1'b1,
        overflowed:    1'b0,
        pending_space: 1'b0
    };

endpackage

`default_nettype wire

### hw/rtl/tsr_byte_if.sv
// ---------------------------------------------------------------------------
// tsr_byte_if
// character channel: one text byte per item with a last marker
// ---------------------------------------------------------------------------
`default_nettype none

interface tsr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/tsr_seed_if.sv
// ---------------------------------------------------------------------------
// tsr_seed_if
// result channel: resolved seed value and its kind
// ---------------------------------------------------------------------------
`default_nettype none

interface tsr_seed_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] seed_value;
    logic        [1:0]  seed_kind;

    modport source (output valid, output seed_value, output seed_kind, input ready);
    modport sink   (input valid, input seed_value, input seed_kind, output ready);
endinterface

`default_nettype wire

### hw/rtl/tsr_accum.sv
// ---------------------------------------------------------------------------
// tsr_accum
// per-byte parse and hash update, snapshot register for finished strings
// ---------------------------------------------------------------------------
`default_nettype none

module tsr_accum (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire tsr_pkg::char_item_t item,
    input  wire logic                fin_take,
    output logic                     fin_valid,
    output tsr_pkg::acc_t            fin
);

    tsr_pkg::acc_t st_reg;
    tsr_pkg::acc_t st_next;
    tsr_pkg::acc_t upd;
    tsr_pkg::acc_t fin_reg;
    logic          fin_valid_reg;
    logic          fin_valid_next;

    logic [7:0]  c;
    logic        is_ws;
    logic        is_digit;
    logic        is_sign;
    logic [3:0]  digit;
    logic [31:0] hash_step;
    logic [67:0] mag_wide;

    assign c        = item.char_code;
    assign is_ws    = (c == tsr_pkg::CHAR_SPACE) ||
                      ((c >= tsr_pkg::CHAR_TAB) && (c <= tsr_pkg::CHAR_CR));
    assign is_digit = (c >= tsr_pkg::CHAR_ZERO) && (c <= tsr_pkg::CHAR_NINE);
    assign is_sign  = (c == tsr_pkg::CHAR_PLUS) || (c == tsr_pkg::CHAR_MINUS);
    assign digit    = 4'(c - tsr_pkg::CHAR_ZERO);

    assign hash_step = st_reg.hash_run * tsr_pkg::HASH_MUL + {24'd0, c};
    // carry out of bit 63 means the magnitude no longer fits in 64 bits
    assign mag_wide  = {4'd0, st_reg.magnitude} * tsr_pkg::RADIX + {64'd0, digit};

    always_comb
    begin
        upd = st_reg;
        if (item.has_char)
        begin
            if (is_ws)
            begin
                if (st_reg.started)
                begin
                    upd.hash_run      = hash_step;
                    upd.pending_space = 1'b1;
                end
            end
            else
            begin
                upd.started       = 1'b1;
                upd.pending_space = 1'b0;
                upd.hash_run      = hash_step;
                upd.hash_last     = hash_step;
                if (st_reg.pending_space)
                begin
                    upd.numeric_ok = 1'b0;
                end
                priority if (is_digit)
                begin
                    upd.digits_seen = 1'b1;
                    if (!st_reg.overflowed)
                    begin
                        if (mag_wide[67:64] != 4'd0)
                        begin
                            upd.overflowed = 1'b1;
                        end
                        else
                        begin
                            upd.magnitude = mag_wide[63:0];
                        end
                    end
                end
                else if (!st_reg.started && is_sign)
                begin
                    upd.is_negative = (c == tsr_pkg::CHAR_MINUS);
                end
                else
                begin
                    upd.numeric_ok = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        if (step)
        begin
            st_next = item.last ? tsr_pkg::ACC_RESET : upd;
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (step && item.last)
        begin
            fin_valid_next = 1'b1;
        end
        else if (fin_take)
        begin
            fin_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= tsr_pkg::ACC_RESET;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && item.last)
        begin
            fin_reg <= upd;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

`default_nettype wire

### hw/rtl/tsr_format.sv
// ---------------------------------------------------------------------------
// tsr_format
// saturation, negation and hash sign extension into the result register
// ---------------------------------------------------------------------------
`default_nettype none

module tsr_format (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fin_valid,
    input  wire tsr_pkg::acc_t  fin,
    output logic                fin_take,
    tsr_seed_if.source          seed
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] value_reg;
    logic [1:0]  kind_reg;
    logic [63:0] value_calc;
    logic [1:0]  kind_calc;
    logic        out_free;
    logic        above_min;

    // magnitude strictly above 2^63
    assign above_min = fin.magnitude[63] && (fin.magnitude[62:0] != 63'd0);

    always_comb
    begin
        priority if (!fin.started)
        begin
            kind_calc  = tsr_pkg::KIND_EMPTY;
            value_calc = 64'd0;
        end
        else if (fin.numeric_ok && fin.digits_seen)
        begin
            kind_calc = tsr_pkg::KIND_NUMERIC;
            if (fin.is_negative)
            begin
                value_calc = (fin.overflowed || above_min) ? tsr_pkg::INT64_MIN_MAG
                                                           : (~fin.magnitude + 64'd1);
            end
            else
            begin
                value_calc = (fin.overflowed || fin.magnitude[63]) ? tsr_pkg::INT64_MAX_MAG
                                                                   : fin.magnitude;
            end
        end
        else
        begin
            kind_calc  = tsr_pkg::KIND_HASH;
            value_calc = {{32{fin.hash_last[31]}}, fin.hash_last};
        end
    end

    assign out_free = !out_valid_reg || seed.ready;
    assign fin_take = fin_valid && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (seed.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_take)
        begin
            value_reg <= value_calc;
            kind_reg  <= kind_calc;
        end
    end

    assign seed.valid      = out_valid_reg;
    assign seed.seed_value = value_reg;
    assign seed.seed_kind  = kind_reg;

endmodule

`default_nettype wire

### hw/rtl/text_seed_resolver.sv
// ---------------------------------------------------------------------------
// text_seed_resolver
// resolves a 64-bit seed from a byte stream: decimal parse or string hash
// ---------------------------------------------------------------------------
//  channel | dir | payload                          | item
//  chars   | in  | char_code[7:0], has_char, last   | one text byte, last ends a string
//  seed    | out | seed_value[63:0] signed, kind[1:0] | one resolved seed per string
//
//  one item per cycle sustained unless an item with last set waits for the snapshot
//  register; the per-byte update of the parse and hash state is one 68-bit
//  multiply-by-ten add plus a 32-bit hash step; a result passes the input,
//  snapshot and output registers; rst_n is asynchronous; it empties all stages
//  and restores the parse state; a stalled result only blocks an item with last
//  set while the snapshot register is also full; ordinary bytes keep flowing
// ---------------------------------------------------------------------------
`default_nettype none

module text_seed_resolver (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tsr_byte_if.sink    chars,
    tsr_seed_if.source  seed
);

    // input register
    logic                s1_valid_reg;
    logic                s1_valid_next;
    tsr_pkg::char_item_t s1_item_reg;
    logic                s1_advance;
    logic                in_accept;

    // snapshot handshake between accumulator and formatter
    logic                fin_valid;
    logic                fin_take;
    tsr_pkg::acc_t       fin;

    // an item without last never needs the snapshot slot
    assign s1_advance = s1_valid_reg && (!s1_item_reg.last || !fin_valid || fin_take);
    assign chars.ready = !s1_valid_reg || s1_advance;
    assign in_accept   = chars.valid && chars.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.char_code <= chars.char_code;
            s1_item_reg.has_char  <= chars.has_char;
            s1_item_reg.last      <= chars.last;
        end
    end

    // parse and hash state, snapshot on last
    tsr_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_advance),
        .item      (s1_item_reg),
        .fin_take  (fin_take),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    // final value selection and result register
    tsr_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_take  (fin_take),
        .seed      (seed)
    );

endmodule

`default_nettype wire

### hw/rtl/tsr_checker.sv
// ---------------------------------------------------------------------------
// tsr_checker
// port-level checks on the seed result channel
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tsr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               seed_valid,
    input wire logic               seed_ready,
    input wire logic signed [63:0] seed_value,
    input wire logic        [1:0]  seed_kind
);

    `TSR_ASSERT_NEXT(a_valid_holds, clk, rst_n, seed_valid && !seed_ready, seed_valid)
    `TSR_ASSERT_NEXT(a_payload_holds, clk, rst_n, seed_valid && !seed_ready,
                     $stable(seed_value) && $stable(seed_kind))
    `TSR_ASSERT_IMPLY(a_empty_is_zero, clk, rst_n,
                      seed_valid && (seed_kind == tsr_pkg::KIND_EMPTY),
                      seed_value == 64'sd0)
    `TSR_ASSERT_IMPLY(a_hash_sign_ext, clk, rst_n,
                      seed_valid && (seed_kind == tsr_pkg::KIND_HASH),
                      seed_value[63:32] == {32{seed_value[31]}})

endmodule

bind text_seed_resolver tsr_checker u_tsr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed_valid (seed.valid),
    .seed_ready (seed.ready),
    .seed_value (seed.seed_value),
    .seed_kind  (seed.seed_kind)
);

`default_nettype wire

### verif/text_seed_resolver_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_seed_resolver_test
// self-checking bench for the seed resolver: a short table of hand-picked
// strings, then about a thousand random text items in three idling phases;
// every result is matched against a pinned seed or an in-bench parser and hash model
// ---------------------------------------------------------------------------

module text_seed_resolver_test;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int LONG_STALL     = 400;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES   = 12;    // output register sits behind the input and snapshot registers
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving
    localparam int NUM_DIRECTED   = 23;

    localparam logic [63:0] U64_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DEC_BASE = 64'd10;

    // one row of stimulus; pinned rows carry their own expected seed
    typedef struct {
        logic [7:0]  code;
        logic        has_char;
        logic        last;
        logic        pinned;
        logic [63:0] value;
        logic [1:0]  kind;
    } plan_row_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  kind;
    } seed_t;

    // running state of the text being parsed
    typedef struct packed {
        logic        started;
        logic [31:0] hash_all;   // every byte since the first non-blank
        logic [31:0] hash_trim;  // up to the last non-blank byte
        logic [63:0] mag;
        logic        neg;
        logic        digits;
        logic        numeric;
        logic        ovf;
        logic        gap;        // blank seen after the text started
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        started: 1'b0, hash_all: 32'd0, hash_trim: 32'd0, mag: 64'd0,
        neg: 1'b0, digits: 1'b0, numeric: 1'b1, ovf: 1'b0, gap: 1'b0
    };

    logic clk = 1'b0;
    logic rst_n;

    tsr_byte_if chars_bus ();
    tsr_seed_if seed_bus ();

    text_seed_resolver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_bus),
        .seed  (seed_bus)
    );

    always #5 clk = ~clk;

    parse_state_t parse = PARSE_CLEAR;
    seed_t        seed_backlog [$];
    int           fault_count = 0;
    int           text_items = 0;

    // idling odds; the sender owns its own, the receiver's is handed over
    // by nonblocking write at a falling edge
    int sender_gap_pct = 37;
    int sink_stall_pct = 49;

    // long receiver hold-off, requested by the stimulus, timed by the receiver
    int backpressure_req = 0;
    int backpressure_ack = 0;
    int stall_left = 0;

    // hand-picked strings; pinned seeds are obvious from the text alone
    plan_row_t directed_plan [NUM_DIRECTED] = '{
        // bare end item with nothing before it: empty text
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'd0, tsr_pkg::KIND_EMPTY},
        // no char and no last: dropped, no result
        '{8'hFF, 1'b0, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_EMPTY},
        // " 7\t": blanks trimmed on both sides
        '{tsr_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{8'h37,               1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{tsr_pkg::CHAR_TAB,   1'b1, 1'b1, 1'b1, 64'd7, tsr_pkg::KIND_NUMERIC},
        // "-0"
        '{tsr_pkg::CHAR_MINUS, 1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{tsr_pkg::CHAR_ZERO,  1'b1, 1'b1, 1'b1, 64'd0, tsr_pkg::KIND_NUMERIC},
        // sign alone is hashed
        '{tsr_pkg::CHAR_PLUS,  1'b1, 1'b1, 1'b1, 64'd43, tsr_pkg::KIND_HASH},
        // "1 2": interior blank spoils the number but is hashed
        '{8'h31,               1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{tsr_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{8'h32,               1'b1, 1'b1, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        // "5-": sign after the first byte
        '{8'h35,               1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{tsr_pkg::CHAR_MINUS, 1'b1, 1'b1, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        // nul byte is an ordinary non-digit
        '{8'h00,               1'b1, 1'b1, 1'b1, 64'd0, tsr_pkg::KIND_HASH},
        // top byte value
        '{8'hFF,               1'b1, 1'b1, 1'b1, 64'd255, tsr_pkg::KIND_HASH},
        // blanks only: empty after trimming
        '{tsr_pkg::CHAR_CR,    1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{8'h0B,               1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{8'h0C,               1'b1, 1'b1, 1'b1, 64'd0, tsr_pkg::KIND_EMPTY},
        // "-9"
        '{tsr_pkg::CHAR_MINUS, 1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{tsr_pkg::CHAR_NINE,  1'b1, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFF7,
          tsr_pkg::KIND_NUMERIC},
        // "9 " closed by a bare end item
        '{tsr_pkg::CHAR_NINE,  1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{tsr_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0, 64'd0, tsr_pkg::KIND_NUMERIC},
        '{8'h5A,               1'b0, 1'b1, 1'b1, 64'd9, tsr_pkg::KIND_NUMERIC}
    };

    // texts right at and just past the 64-bit limits
    string limit_texts [4] = '{
        "9223372036854775807", "9223372036854775808",
        "18446744073709551615", "18446744073709551616"
    };

    // ---------------------------------------------------------------------
    // parser and hash model
    // ---------------------------------------------------------------------

    function automatic void scan_char(input logic [7:0] c);
        logic [63:0] digit;
        logic        opening;
        if (c == tsr_pkg::CHAR_SPACE || (c >= tsr_pkg::CHAR_TAB && c <= tsr_pkg::CHAR_CR))
        begin
            // leading blanks vanish; later ones are hashed but not yet trimmed
            if (parse.started)
            begin
                parse.hash_all = parse.hash_all * tsr_pkg::HASH_MUL + 32'(c);
                parse.gap = 1'b1;
            end
        end
        else
        begin
            opening = !parse.started;
            parse.started = 1'b1;
            if (parse.gap)
                parse.numeric = 1'b0;
            parse.gap = 1'b0;
            parse.hash_all = parse.hash_all * tsr_pkg::HASH_MUL + 32'(c);
            parse.hash_trim = parse.hash_all;
            if (c >= tsr_pkg::CHAR_ZERO && c <= tsr_pkg::CHAR_NINE)
            begin
                digit = 64'(c - tsr_pkg::CHAR_ZERO);
                parse.digits = 1'b1;
                // once past 64 bits the magnitude is frozen
                if (!parse.ovf)
                begin
                    if (parse.mag > (U64_MAX - digit) / DEC_BASE)
                        parse.ovf = 1'b1;
                    else
                        parse.mag = parse.mag * DEC_BASE + digit;
                end
            end
            else if (opening && (c == tsr_pkg::CHAR_PLUS || c == tsr_pkg::CHAR_MINUS))
                parse.neg = (c == tsr_pkg::CHAR_MINUS);
            else
                parse.numeric = 1'b0;
        end
    endfunction

    // closes the current text and clears the parse state
    function automatic seed_t resolve_seed();
        seed_t r;
        if (!parse.started)
            r = '{value: 64'd0, kind: tsr_pkg::KIND_EMPTY};
        else if (parse.numeric && parse.digits)
        begin
            r.kind = tsr_pkg::KIND_NUMERIC;
            if (parse.neg)
                r.value = (parse.ovf || parse.mag > tsr_pkg::INT64_MIN_MAG)
                          ? tsr_pkg::INT64_MIN_MAG : -parse.mag;
            else
                r.value = (parse.ovf || parse.mag > tsr_pkg::INT64_MAX_MAG)
                          ? tsr_pkg::INT64_MAX_MAG : parse.mag;
        end
        else
            r = '{value: {{32{parse.hash_trim[31]}}, parse.hash_trim},
                  kind: tsr_pkg::KIND_HASH};
        parse = PARSE_CLEAR;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // sender side, called and returning at a falling edge
    // ---------------------------------------------------------------------

    task automatic offer_item(input plan_row_t row);
        seed_t outcome;
        // random gaps, payload scrambled while idle
        while ($urandom_range(99) < sender_gap_pct)
        begin
            chars_bus.valid     <= 1'b0;
            chars_bus.char_code <= 8'($urandom_range(255));
            chars_bus.has_char  <= 1'($urandom_range(1));
            chars_bus.last      <= 1'($urandom_range(1));
            @(negedge clk);
        end
        chars_bus.valid     <= 1'b1;
        chars_bus.char_code <= row.code;
        chars_bus.has_char  <= row.has_char;
        chars_bus.last      <= row.last;
        @(posedge clk);
        while (!chars_bus.ready)
            @(posedge clk);
        // item taken at this edge: advance the model
        if (row.has_char)
            scan_char(row.code);
        if (row.last)
        begin
            outcome = resolve_seed();
            if (row.pinned)
                outcome = '{value: row.value, kind: row.kind};
            seed_backlog = {seed_backlog, outcome};
        end
        if (row.has_char || row.last)
            text_items++;
        @(negedge clk);
    endtask

    // sender goes quiet until every pending seed has come out
    task automatic hold_for_results();
        chars_bus.valid <= 1'b0;
        @(negedge clk);
        while (seed_backlog.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(5);
        return (k == 0) ? tsr_pkg::CHAR_SPACE : 8'(tsr_pkg::CHAR_TAB + k - 1);
    endfunction

    // one random text: mostly well-formed numbers with random content,
    // some spoiled by one stray byte, some raw bytes, some blanks only
    task automatic send_random_string();
        logic [7:0] text [$];
        int         pick;
        int         n;
        int         spoil;
        logic       bare_end;
        string      lim;
        plan_row_t  row;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            repeat ($urandom_range(2)) text = {text, pick_blank()};
            case ($urandom_range(2))
                1: text = {text, tsr_pkg::CHAR_PLUS};
                2: text = {text, tsr_pkg::CHAR_MINUS};
                default: ;
            endcase
            if ($urandom_range(9) == 0)
            begin
                lim = limit_texts[$urandom_range(3)];
                for (int i = 0; i < lim.len(); i++)
                    text = {text, 8'(lim[i])};
            end
            else
            begin
                // long runs are rare; they cost many items each
                n = ($urandom_range(9) == 0) ? $urandom_range(22, 7) : $urandom_range(5, 1);
                repeat (n) text = {text, 8'(tsr_pkg::CHAR_ZERO + $urandom_range(9))};
            end
            repeat ($urandom_range(2)) text = {text, pick_blank()};
            if (pick >= 55)
            begin
                // a blank, a sign or any byte dropped somewhere in the text
                spoil = $urandom_range(2);
                text.insert($urandom_range(text.size()),
                            (spoil == 0) ? pick_blank() :
                            (spoil == 1) ? ($urandom_range(1) ? tsr_pkg::CHAR_PLUS
                                                              : tsr_pkg::CHAR_MINUS) :
                                           8'($urandom_range(255)));
            end
        end
        else if (pick < 90)
            repeat ($urandom_range(8)) text = {text, 8'($urandom_range(255))};
        else
            repeat ($urandom_range(3)) text = {text, pick_blank()};

        bare_end = (text.size() == 0) || ($urandom_range(3) == 0);
        foreach (text[i])
        begin
            // now and then an empty item that the block must drop
            if ($urandom_range(19) == 0)
            begin
                row = '{8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 64'd0,
                        tsr_pkg::KIND_EMPTY};
                offer_item(row);
            end
            row = '{text[i], 1'b1, !bare_end && (i == text.size() - 1), 1'b0, 64'd0,
                    tsr_pkg::KIND_NUMERIC};
            offer_item(row);
        end
        if (bare_end)
        begin
            row = '{8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 64'd0, tsr_pkg::KIND_EMPTY};
            offer_item(row);
        end
    endtask

    // ---------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            seed_bus.ready <= 1'b0;
        end
        else if (backpressure_req != backpressure_ack)
        begin
            backpressure_ack = backpressure_req;
            stall_left = LONG_STALL - 1;
            seed_bus.ready <= 1'b0;
        end
        else
            seed_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------------
    // result check, oldest expectation first
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        seed_t want;
        if (rst_n && seed_bus.valid && seed_bus.ready)
        begin
            if (seed_backlog.size() == 0)
            begin
                $error("unexpected seed item: seed_value %0d seed_kind %0d",
                       seed_bus.seed_value, seed_bus.seed_kind);
                fault_count++;
            end
            else
            begin
                want = seed_backlog.pop_front();
                if (seed_bus.seed_value !== want.value)
                begin
                    $error("seed_value mismatch: expected %0d, actual %0d",
                           $signed(want.value), seed_bus.seed_value);
                    fault_count++;
                end
                if (seed_bus.seed_kind !== want.kind)
                begin
                    $error("seed_kind mismatch: expected %0d, actual %0d",
                           want.kind, seed_bus.seed_kind);
                    fault_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // watchdog on cycles where neither channel moves an item
    // ---------------------------------------------------------------------

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (chars_bus.valid && chars_bus.ready) ||
            (seed_bus.valid && seed_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        int stage;
        stage = 0;
        rst_n               = 1'b0;
        chars_bus.valid     = 1'b0;
        chars_bus.char_code = 8'd0;
        chars_bus.has_char  = 1'b0;
        chars_bus.last      = 1'b0;
        seed_bus.ready      = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase one: sender idles 37 of 100, receiver 49
        foreach (directed_plan[i])
            offer_item(directed_plan[i]);

        text_items = 0;
        while (text_items < RANDOM_ITEMS)
        begin
            if (stage == 0 && text_items >= RANDOM_ITEMS / 3)
            begin
                // phase two: roles swapped
                hold_for_results();
                stage = 1;
                sender_gap_pct = 49;
                sink_stall_pct <= 37;
            end
            else if (stage == 1 && text_items >= 2 * RANDOM_ITEMS / 3)
            begin
                // phase three: no idling, opened by a long receiver hold-off
                // so the block fills and pushes back on its input
                hold_for_results();
                stage = 2;
                sender_gap_pct = 0;
                sink_stall_pct <= 0;
                backpressure_req <= backpressure_req + 1;
            end
            send_random_string();
        end

        hold_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
